@@ rtl/mlfq_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared constants and controller/datapath interface types for the
// three-level feedback-queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfq_pkg;

    localparam int LEVELS = 3;

    // input kinds
    localparam logic FUNC_ADD      = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    // result status codes
    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_RAN     = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;

    // config register indexes
    localparam logic [1:0] CFG_SLICE0    = 2'd0;
    localparam logic [1:0] CFG_SLICE1    = 2'd1;
    localparam logic [1:0] CFG_SLICE2    = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD = 2'd3;

    localparam logic [9:0]  SLICE0_RST    = 10'd10;
    localparam logic [9:0]  SLICE1_RST    = 10'd20;
    localparam logic [9:0]  SLICE2_RST    = 10'd40;
    localparam logic [15:0] THRESHOLD_RST = 16'd50;

    localparam logic [1:0] LVL_TOP    = 2'd0;
    localparam logic [1:0] LVL_MID    = 2'd1;
    localparam logic [1:0] LVL_BOTTOM = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic take_in;
        logic add;
        logic scan_init;
        logic post;
        logic scan_open;
        logic scan_next;
        logic scan_ev;
        logic sel;
        logic pop_rd;
        logic pop;
        logic append;
        logic load_out;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic is_add;
        logic sc_ne;
        logic sc_last;
        logic sc_stop;
        logic sel_found;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/mlfq_ram.sv @@
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/mlfq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: add, pre-dispatch promotion scan, level select, pop/run,
// requeue, aging scan with promotion, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire mlfq_pkg::t_sts i_sts,
    output mlfq_pkg::t_cmd     o_cmd
);
    import mlfq_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_ADD     = 4'd2;
    localparam logic [3:0] S_SC_OPEN = 4'd3;
    localparam logic [3:0] S_SC_RD   = 4'd4;
    localparam logic [3:0] S_SC_EV   = 4'd5;
    localparam logic [3:0] S_SEL     = 4'd6;
    localparam logic [3:0] S_POP_RD  = 4'd7;
    localparam logic [3:0] S_POP     = 4'd8;
    localparam logic [3:0] S_APPEND  = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_post, n_post;
    logic [3:0] w_phase_done;

    assign w_phase_done = r_post ? S_OUT : S_SEL;

    always_comb begin
        n_state    = r_state;
        n_post     = r_post;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_add) begin
                    n_state = S_ADD;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_post          = 1'b0;
                    n_state         = S_SC_OPEN;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_OUT;
            end
            S_SC_OPEN: begin
                if (i_sts.sc_ne) begin
                    o_cmd.scan_open = 1'b1;
                    n_state         = S_SC_RD;
                end else if (i_sts.sc_last) begin
                    n_state = w_phase_done;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_SC_RD: begin
                n_state = S_SC_EV;
            end
            S_SC_EV: begin
                o_cmd.scan_ev = 1'b1;
                if (!i_sts.sc_stop) begin
                    n_state = S_SC_RD;
                end else if (i_sts.sc_last) begin
                    n_state = w_phase_done;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SC_OPEN;
                end
            end
            S_SEL: begin
                o_cmd.sel = 1'b1;
                n_state   = i_sts.sel_found ? S_POP_RD : S_OUT;
            end
            S_POP_RD: begin
                o_cmd.pop_rd = 1'b1;
                n_state      = S_POP;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_APPEND;
            end
            S_APPEND: begin
                o_cmd.append    = 1'b1;
                o_cmd.scan_init = 1'b1;
                o_cmd.post      = 1'b1;
                n_post          = 1'b1;
                n_state         = S_SC_OPEN;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_post  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_post  <= n_post;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mlfq_dp.sv @@
// ----------------------------------------------------------------------------
// mlfq_dp
// Datapath: config registers, process table RAMs, queue pointers, free map,
// level cursor, list walker with aging/promotion, result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_dp #(
    parameter int MAX_PROCESSES = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mlfq_pkg::t_cmd i_cmd,
    output mlfq_pkg::t_sts      o_sts,
    input  wire logic [31:0]    i_in_data,
    input  wire logic           i_in_user,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_addr,
    input  wire logic [15:0]    i_cfg_wdata,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output logic [63:0]         o_out_data,
    output logic [2:0]          o_out_user
);
    import mlfq_pkg::*;

    localparam int IW = $clog2(MAX_PROCESSES);

    // configuration
    logic [9:0]  r_slice [LEVELS];
    logic [15:0] r_thr;

    // latched input
    logic        r_func;
    logic [7:0]  r_name;
    logic [15:0] r_size;
    logic [2:0]  r_level;

    // queues and table control
    logic [IW-1:0]            r_head [LEVELS];
    logic [IW-1:0]            r_tail [LEVELS];
    logic [LEVELS-1:0]        r_ne;
    logic [MAX_PROCESSES-1:0] r_free;
    logic [15:0]              r_pid;
    logic [1:0]               r_cursor;
    logic                     r_phw;

    // walker
    logic [1:0]    r_sc_lv;
    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_stop;
    logic [9:0]    r_addend;
    logic [IW:0]   r_cnt;

    // run
    logic [1:0]    r_lv;
    logic [IW-1:0] r_h;
    logic [1:0]    r_nxt;
    logic          r_done;

    // pending result
    logic [2:0]  r_res_status;
    logic [15:0] r_res_pid;
    logic [7:0]  r_res_name;
    logic [1:0]  r_res_level;
    logic [9:0]  r_res_slice;
    logic [16:0] r_res_left;
    logic        r_res_fin;
    logic [1:0]  r_res_next;

    // RAM read data
    logic [7:0]    w_label_rd;
    logic [15:0]   w_work_rd;
    logic [15:0]   w_wait_rd;
    logic [15:0]   w_pid_rd;
    logic [IW-1:0] w_link_rd;

    logic [IW-1:0] w_raddr;
    assign w_raddr = i_cmd.pop_rd ? r_head[r_lv] : r_cur;

    // first free slot
    logic          w_free_found;
    logic [IW-1:0] w_slot;
    always_comb begin
        w_free_found = 1'b0;
        w_slot       = '0;
        for (int i = MAX_PROCESSES - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                w_free_found = 1'b1;
                w_slot       = IW'(i);
            end
        end
    end

    logic        w_lvl_ok, w_add_ok;
    logic [15:0] w_pid_inc;
    assign w_lvl_ok  = r_level < 3'(LEVELS);
    assign w_add_ok  = i_cmd.add && w_lvl_ok && w_free_found;
    assign w_pid_inc = r_pid + 16'd1;

    // level select
    logic [LEVELS-1:0] w_ge_mask, w_cand;
    logic              w_f1v, w_sel_found;
    logic [1:0]        w_f1, w_f0, w_sel_lv;
    always_comb begin
        unique case (r_cursor)
            LVL_TOP:    w_ge_mask = 3'b111;
            LVL_MID:    w_ge_mask = 3'b110;
            default:    w_ge_mask = 3'b100;
        endcase
        w_cand      = r_ne & w_ge_mask;
        w_f1v       = |w_cand;
        w_f1        = w_cand[0] ? LVL_TOP : (w_cand[1] ? LVL_MID : LVL_BOTTOM);
        w_f0        = r_ne[0] ? LVL_TOP : (r_ne[1] ? LVL_MID : LVL_BOTTOM);
        w_sel_found = w_f1v || (r_phw && (|r_ne));
        w_sel_lv    = w_f1v ? w_f1 : w_f0;
    end

    // run arithmetic
    logic [9:0]  w_run_slice;
    logic [16:0] w_left;
    logic        w_run_done;
    logic [1:0]  w_nxt;
    assign w_run_slice = r_slice[r_lv];
    assign w_left      = {1'b0, w_work_rd} - {7'b0, w_run_slice};
    assign w_run_done  = w_left[16] || (w_left == 17'd0);
    assign w_nxt       = w_run_done ? LVL_TOP : ((r_lv == LVL_BOTTOM) ? LVL_BOTTOM : r_lv + 2'd1);

    // aging and promotion of one walked entry
    logic [16:0] w_wsum;
    logic [15:0] w_wsat, w_wnew;
    logic        w_prom;
    logic [1:0]  w_dest;
    assign w_wsum = {1'b0, w_wait_rd} + {7'b0, r_addend};
    assign w_wsat = w_wsum[16] ? 16'hFFFF : w_wsum[15:0];
    assign w_prom = w_wsat >= r_thr;
    assign w_wnew = w_prom ? 16'd0 : w_wsat;
    assign w_dest = w_prom ? r_sc_lv - 2'd1 : r_sc_lv;

    // shared tail-append port
    logic          w_app_en;
    logic [1:0]    w_app_lv;
    logic [IW-1:0] w_app_e;
    always_comb begin
        w_app_en = 1'b0;
        w_app_lv = r_level[1:0];
        w_app_e  = w_slot;
        if (w_add_ok) begin
            w_app_en = 1'b1;
        end else if (i_cmd.scan_ev) begin
            w_app_en = 1'b1;
            w_app_lv = w_dest;
            w_app_e  = r_cur;
        end else if (i_cmd.append && !r_done) begin
            w_app_en = 1'b1;
            w_app_lv = r_nxt;
            w_app_e  = r_h;
        end
    end

    logic w_link_we;
    assign w_link_we = w_app_en && r_ne[w_app_lv];

    logic          w_work_we, w_wait_we;
    logic [IW-1:0] w_work_wa, w_wait_wa;
    logic [15:0]   w_work_wd, w_wait_wd;
    assign w_work_we = w_add_ok || (i_cmd.pop && !w_run_done);
    assign w_work_wa = w_add_ok ? w_slot : r_h;
    assign w_work_wd = w_add_ok ? r_size : w_left[15:0];
    assign w_wait_we = w_add_ok || i_cmd.scan_ev;
    assign w_wait_wa = w_add_ok ? w_slot : r_cur;
    assign w_wait_wd = w_add_ok ? 16'd0 : w_wnew;

    mlfq_ram #(.WIDTH(8), .DEPTH(MAX_PROCESSES)) u_label (
        .i_clk(i_clk), .i_we(w_add_ok), .i_waddr(w_slot), .i_wdata(r_name),
        .i_raddr(w_raddr), .o_rdata(w_label_rd)
    );
    mlfq_ram #(.WIDTH(16), .DEPTH(MAX_PROCESSES)) u_work (
        .i_clk(i_clk), .i_we(w_work_we), .i_waddr(w_work_wa), .i_wdata(w_work_wd),
        .i_raddr(w_raddr), .o_rdata(w_work_rd)
    );
    mlfq_ram #(.WIDTH(16), .DEPTH(MAX_PROCESSES)) u_wait (
        .i_clk(i_clk), .i_we(w_wait_we), .i_waddr(w_wait_wa), .i_wdata(w_wait_wd),
        .i_raddr(w_raddr), .o_rdata(w_wait_rd)
    );
    mlfq_ram #(.WIDTH(16), .DEPTH(MAX_PROCESSES)) u_pid (
        .i_clk(i_clk), .i_we(w_add_ok), .i_waddr(w_slot), .i_wdata(w_pid_inc),
        .i_raddr(w_raddr), .o_rdata(w_pid_rd)
    );
    mlfq_ram #(.WIDTH(IW), .DEPTH(MAX_PROCESSES)) u_link (
        .i_clk(i_clk), .i_we(w_link_we), .i_waddr(r_tail[w_app_lv]), .i_wdata(w_app_e),
        .i_raddr(w_raddr), .o_rdata(w_link_rd)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice[0] <= SLICE0_RST;
            r_slice[1] <= SLICE1_RST;
            r_slice[2] <= SLICE2_RST;
            r_thr      <= THRESHOLD_RST;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
            end
            r_ne        <= '0;
            r_free      <= '1;
            r_pid       <= '0;
            r_cursor    <= LVL_TOP;
            r_phw       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_SLICE0:    r_slice[0] <= i_cfg_wdata[9:0];
                    CFG_SLICE1:    r_slice[1] <= i_cfg_wdata[9:0];
                    CFG_SLICE2:    r_slice[2] <= i_cfg_wdata[9:0];
                    CFG_THRESHOLD: r_thr      <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.add && (!w_lvl_ok || w_free_found)) begin
                r_pid <= w_pid_inc;
            end
            if (w_add_ok) begin
                r_free[w_slot] <= 1'b0;
            end
            if (i_cmd.scan_open) begin
                r_ne[r_sc_lv] <= 1'b0;
            end
            if (i_cmd.sel) begin
                r_cursor <= w_sel_found ? w_sel_lv : LVL_TOP;
                r_phw    <= w_sel_found;
            end
            if (i_cmd.pop) begin
                if (r_h == r_tail[r_lv]) begin
                    r_ne[r_lv] <= 1'b0;
                end else begin
                    r_head[r_lv] <= w_link_rd;
                end
                if (w_run_done) begin
                    r_free[r_h] <= 1'b1;
                end
            end
            if (w_app_en) begin
                if (!r_ne[w_app_lv]) begin
                    r_head[w_app_lv] <= w_app_e;
                end
                r_tail[w_app_lv] <= w_app_e;
                r_ne[w_app_lv]   <= 1'b1;
            end
            if (i_cmd.load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_func  <= i_in_user;
            r_name  <= i_in_data[7:0];
            r_size  <= i_in_data[23:8];
            r_level <= i_in_data[26:24];
        end
        if (i_cmd.scan_init) begin
            r_sc_lv  <= LVL_MID;
            r_cnt    <= '0;
            r_addend <= i_cmd.post ? r_res_slice : 10'd0;
        end else if (i_cmd.scan_next) begin
            r_sc_lv <= r_sc_lv + 2'd1;
        end
        if (i_cmd.scan_open) begin
            r_cur  <= r_head[r_sc_lv];
            r_stop <= r_tail[r_sc_lv];
        end
        if (i_cmd.scan_ev) begin
            r_cnt <= r_cnt + (IW+1)'(w_prom);
            if (r_cur != r_stop) begin
                r_cur <= w_link_rd;
            end
        end
        if (i_cmd.add) begin
            r_res_status <= !w_lvl_ok ? ST_INVALID : (w_free_found ? ST_ADDED : ST_FULL);
            r_res_pid    <= (!w_lvl_ok || w_free_found) ? w_pid_inc : 16'd0;
            r_res_name   <= '0;
            r_res_level  <= '0;
            r_res_slice  <= '0;
            r_res_left   <= '0;
            r_res_fin    <= 1'b0;
            r_res_next   <= '0;
        end
        if (i_cmd.sel) begin
            r_lv <= w_sel_lv;
            if (!w_sel_found) begin
                r_res_status <= ST_IDLE;
                r_res_pid    <= '0;
                r_res_name   <= '0;
                r_res_level  <= '0;
                r_res_slice  <= '0;
                r_res_left   <= '0;
                r_res_fin    <= 1'b0;
                r_res_next   <= '0;
            end
        end
        if (i_cmd.pop_rd) begin
            r_h <= r_head[r_lv];
        end
        if (i_cmd.pop) begin
            r_done       <= w_run_done;
            r_nxt        <= w_nxt;
            r_res_status <= ST_RAN;
            r_res_pid    <= w_pid_rd;
            r_res_name   <= w_label_rd;
            r_res_level  <= r_lv;
            r_res_slice  <= w_run_slice;
            r_res_left   <= w_left;
            r_res_fin    <= w_run_done;
            r_res_next   <= w_nxt;
        end
        if (i_cmd.load_out) begin
            o_out_user <= r_res_status;
            o_out_data <= {3'b0,
                           (r_res_status == ST_RAN) ? 5'(r_cnt) : 5'd0,
                           r_res_next, r_res_fin, r_res_left, r_res_slice,
                           r_res_level, r_res_name, r_res_pid};
        end
    end

    assign o_sts.is_add    = r_func == FUNC_ADD;
    assign o_sts.sc_ne     = r_ne[r_sc_lv];
    assign o_sts.sc_last   = r_sc_lv == LVL_BOTTOM;
    assign o_sts.sc_stop   = r_cur == r_stop;
    assign o_sts.sel_found = w_sel_found;
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

    // checks
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_ne[r_lv])
        else $error("pop from an empty queue");

    a_open_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_open |=> !r_ne[$past(r_sc_lv)])
        else $error("walked queue not detached");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor != 2'd3)
        else $error("level cursor out of range");

    a_add_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_add_ok |=> !r_free[$past(w_slot)])
        else $error("allocated slot still marked free");

endmodule

`default_nettype wire

@@ rtl/mlfq_scheduler_with_aging.sv @@
// ----------------------------------------------------------------------------
// mlfq_scheduler_with_aging
// Three-level feedback-queue process scheduler with waiting-time promotion.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_axis): tuser = func (0 add, 1 dispatch); tdata carries
//    new_name[7:0], new_size[23:8], new_level[26:24]. One transfer per item.
//  - Output stream (m_axis): exactly one result per input item; tuser is the
//    status code, tdata the run details (see port comments).
//  - Config: write i_cfg_we/i_cfg_addr/i_cfg_wdata only while idle.
//  - Add: decode, table write and queue append, then result load.
//  - Dispatch: two list walks over queues 1 and 2, each queued entry
//    taking one table RAM read, then update/requeue, plus the control
//    steps (4 queue opens, decode, select, two pop steps, requeue, result
//    load). Dispatch time grows with the processes queued at levels 1
//    and 2: the list walker and the single read port of the table RAMs
//    handle one entry at a time.
//  - One item in flight; s_axis_tready is high only between items. The
//    result register lets a new item be taken while a result waits; a
//    stalled m_axis holds the next result in the sequencer until free.
//  - Reset (synchronous, active low): all queues empty, all entries free,
//    pid counter and level cursor zero, slices 10/20/40, threshold 50.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_scheduler_with_aging #(
    parameter int MAX_PROCESSES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // new_name[7:0], new_size[23:8], new_level[26:24]
    input  wire logic        s_axis_tuser,   // func[0]
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // pid_out[15:0], run_name[23:16],
                                             // run_level[25:24], run_slice[35:26],
                                             // size_left[52:36], finished[53],
                                             // next_level[55:54], promoted_count[60:56]
    output logic [2:0]       m_axis_tuser,   // status[2:0]
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);
    import mlfq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    mlfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // table, queues, arithmetic and result register
    mlfq_dp #(.MAX_PROCESSES(MAX_PROCESSES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ verif/mlfq_scheduler_with_aging_test.sv @@
// ----------------------------------------------------------------------------
// mlfq_scheduler_with_aging_test
// Stream-level check of the feedback-queue scheduler: a local scheduler
// model predicts every result; random adds and dispatches, directed corner
// items, register phases and random stalls on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_scheduler_with_aging_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mlfq_pkg::*;

    localparam int NPROC = 16;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic       func;
        logic [7:0] name;
        logic [15:0] size;
        logic [2:0] level;
    } t_job;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] pid;
        logic [7:0]  name;
        logic [1:0]  lvl;
        logic [9:0]  slice;
        logic [16:0] left;
        logic        done;
        logic [1:0]  nxt;
        logic [4:0]  promo;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;

    mlfq_scheduler_with_aging uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- scheduler model ----------------
    logic [9:0]  sl_cfg [3];
    logic [15:0] thr_cfg;
    logic [7:0]  ent_name [NPROC];
    logic [15:0] ent_work [NPROC];
    logic [15:0] ent_wait [NPROC];
    logic [15:0] ent_pid  [NPROC];
    logic [3:0]  ent_link [NPROC];
    logic        ent_free [NPROC];
    logic [3:0]  q_hd [3];
    logic [3:0]  q_tl [3];
    logic        q_ne [3];
    logic [15:0] pid_ctr;
    int          cursor;
    logic        pass_work;

    function automatic void model_reset();
        sl_cfg[0] = SLICE0_RST; sl_cfg[1] = SLICE1_RST; sl_cfg[2] = SLICE2_RST;
        thr_cfg = THRESHOLD_RST;
        for (int i = 0; i < NPROC; i++) begin
            ent_free[i] = 1'b1; ent_link[i] = '0; ent_wait[i] = '0;
        end
        for (int l = 0; l < 3; l++) begin
            q_hd[l] = '0; q_tl[l] = '0; q_ne[l] = 1'b0;
        end
        pid_ctr = '0; cursor = 0; pass_work = 1'b0;
    endfunction

    function automatic void q_push(int lv, logic [3:0] e);
        ent_link[e] = '0;
        if (q_ne[lv]) ent_link[q_tl[lv]] = e;
        else q_hd[lv] = e;
        q_tl[lv] = e;
        q_ne[lv] = 1'b1;
    endfunction

    // walk one level's list in order
    function automatic int q_list(int lv, ref logic [3:0] buf_e [NPROC]);
        int n;
        logic [3:0] e;
        n = 0;
        if (!q_ne[lv]) return 0;
        e = q_hd[lv];
        while (n < NPROC) begin
            buf_e[n] = e; n++;
            if (e == q_tl[lv]) break;
            e = ent_link[e];
        end
        return n;
    endfunction

    function automatic int aging_scan();
        logic [3:0] buf_e [NPROC];
        int n, cnt;
        cnt = 0;
        for (int lv = 1; lv < 3; lv++) begin
            n = q_list(lv, buf_e);
            q_ne[lv] = 1'b0;
            for (int k = 0; k < n; k++) begin
                if (ent_wait[buf_e[k]] >= thr_cfg) begin
                    ent_wait[buf_e[k]] = '0;
                    q_push(lv - 1, buf_e[k]);
                    cnt++;
                end else begin
                    q_push(lv, buf_e[k]);
                end
            end
        end
        return cnt;
    endfunction

    function automatic void wait_grow(logic [9:0] t);
        logic [3:0] buf_e [NPROC];
        int n, w;
        for (int lv = 1; lv < 3; lv++) begin
            n = q_list(lv, buf_e);
            for (int k = 0; k < n; k++) begin
                w = ent_wait[buf_e[k]] + t;
                ent_wait[buf_e[k]] = (w > 65535) ? 16'hFFFF : w[15:0];
            end
        end
    endfunction

    function automatic t_res schedule_step(t_job j);
        t_res r;
        int slot, lv, left, cnt, nx;
        logic found;
        logic [3:0] e;
        r = '0;
        if (j.func == FUNC_ADD) begin
            if (j.level >= 3) begin
                pid_ctr++;
                r.status = ST_INVALID; r.pid = pid_ctr;
                return r;
            end
            slot = -1;
            for (int i = NPROC - 1; i >= 0; i--) if (ent_free[i]) slot = i;
            if (slot < 0) begin
                r.status = ST_FULL;
                return r;
            end
            pid_ctr++;
            ent_free[slot] = 1'b0; ent_name[slot] = j.name; ent_work[slot] = j.size;
            ent_wait[slot] = '0; ent_pid[slot] = pid_ctr;
            q_push(j.level, slot[3:0]);
            r.status = ST_ADDED; r.pid = pid_ctr;
            return r;
        end
        void'(aging_scan());
        found = 1'b0;
        for (int g = 0; g < 7; g++) begin
            if (cursor >= 3) begin
                if (pass_work) begin
                    cursor = 0; pass_work = 1'b0; continue;
                end
                break;
            end
            if (q_ne[cursor]) begin
                found = 1'b1; break;
            end
            cursor++;
        end
        if (!found) begin
            cursor = 0; pass_work = 1'b0;
            r.status = ST_IDLE;
            return r;
        end
        lv = cursor;
        pass_work = 1'b1;
        e = q_hd[lv];
        if (e == q_tl[lv]) q_ne[lv] = 1'b0;
        else q_hd[lv] = ent_link[e];
        left = int'(ent_work[e]) - int'(sl_cfg[lv]);
        nx = 0;
        if (left > 0) begin
            nx = (lv < 2) ? lv + 1 : lv;
            ent_work[e] = left[15:0];
            q_push(nx, e);
        end else begin
            ent_free[e] = 1'b1;
        end
        wait_grow(sl_cfg[lv]);
        cnt = aging_scan();
        r.status = ST_RAN; r.pid = ent_pid[e]; r.name = ent_name[e];
        r.lvl = lv[1:0]; r.slice = sl_cfg[lv]; r.left = left[16:0];
        r.done = (left <= 0); r.nxt = nx[1:0]; r.promo = cnt[4:0];
        return r;
    endfunction

    // ---------------- driver ----------------
    t_job pending_jobs [$];
    t_res expected_results [$];
    int   errors = 0;
    int   cycles = 0;
    int   send_gap = 0;
    int   hold_cycles = 0;   // long receiver hold-off, counted by the monitor

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            expected_results.push_back(schedule_step({s_axis_tuser, s_axis_tdata[7:0],
                                                      s_axis_tdata[23:8],
                                                      s_axis_tdata[26:24]}));
        end
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the offered item
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (pending_jobs.size() > 0) begin
            t_job j;
            j = pending_jobs.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= j.func;
            s_axis_tdata <= {5'd0, j.level, j.size, j.name};
            send_gap <= pick_gap();
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want, cycles);
    endtask

    int recv_gap = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            t_res w, g;
            g = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tdata[25:24],
                 m_axis_tdata[35:26], m_axis_tdata[52:36], m_axis_tdata[53],
                 m_axis_tdata[55:54], m_axis_tdata[60:56]};
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", {m_axis_tuser, m_axis_tdata[60:0]}, '0);
            end else begin
                w = expected_results.pop_front();
                if (g.status != w.status) report_mismatch("status", g.status, w.status);
                if (g.pid != w.pid) report_mismatch("pid_out", g.pid, w.pid);
                if (g.name != w.name) report_mismatch("run_name", g.name, w.name);
                if (g.lvl != w.lvl) report_mismatch("run_level", g.lvl, w.lvl);
                if (g.slice != w.slice) report_mismatch("run_slice", g.slice, w.slice);
                if (g.left != w.left) report_mismatch("size_left", g.left, w.left);
                if (g.done != w.done) report_mismatch("finished", g.done, w.done);
                if (g.nxt != w.nxt) report_mismatch("next_level", g.nxt, w.nxt);
                if (g.promo != w.promo) report_mismatch("promoted_count", g.promo, w.promo);
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (m_axis_tvalid) recv_gap <= pick_gap();
        end
        if (cycles > LIMIT) begin
            $display("mlfq_scheduler_with_aging_test failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic t_job mk_add(logic [7:0] nm, logic [15:0] sz, logic [2:0] lv);
        t_job j;
        j.func = FUNC_ADD; j.name = nm; j.size = sz; j.level = lv;
        return j;
    endfunction

    function automatic t_job mk_disp();
        t_job j;
        j = 28'($urandom);
        j.func = FUNC_DISPATCH;
        return j;
    endfunction

    function automatic t_job rand_add();
        logic [15:0] sz;
        case ($urandom_range(0, 3))
            0: sz = 16'($urandom_range(0, 30));
            1: sz = 16'($urandom_range(0, 200));
            2: sz = 16'($urandom_range(0, 2000));
            default: sz = 16'($urandom);
        endcase
        return mk_add(8'($urandom), sz,
                      ($urandom_range(0, 9) == 0) ? 3'($urandom_range(3, 7))
                                                  : 3'($urandom_range(0, 2)));
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_addr <= idx; i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD) thr_cfg = v;
        else sl_cfg[idx] = v[9:0];
    endtask

    task automatic drain();
        while (pending_jobs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 45) pending_jobs.push_back(rand_add());
            else pending_jobs.push_back(mk_disp());
        end
    endtask

    initial begin
        model_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle on empty, field extremes, invalid levels, a burst of fourteen adds
        pending_jobs.push_back(mk_disp());
        pending_jobs.push_back(mk_add(8'h00, 16'h0000, 3'd0));
        pending_jobs.push_back(mk_add(8'hFF, 16'hFFFF, 3'd2));
        pending_jobs.push_back(mk_add(8'hA5, 16'd15, 3'd1));
        pending_jobs.push_back(mk_add(8'h5A, 16'd3, 3'd7));
        pending_jobs.push_back(mk_add(8'h11, 16'd1, 3'd3));
        for (int k = 0; k < 6; k++) pending_jobs.push_back(mk_disp());
        for (int k = 0; k < 14; k++)
            pending_jobs.push_back(mk_add(8'(k), 16'(500 + k), 3'(k % 3)));
        // sender stays quiet until every result is back
        drain();

        // long receiver hold while the sender keeps offering
        hold_cycles = 400;
        random_phase(150);
        drain();

        // extremes: tiny slices, zero threshold
        cfg_write(CFG_SLICE0, 16'd1);
        cfg_write(CFG_SLICE1, 16'd1);
        cfg_write(CFG_SLICE2, 16'd1);
        cfg_write(CFG_THRESHOLD, 16'd0);
        random_phase(250);
        drain();

        // large slices, max threshold
        cfg_write(CFG_SLICE0, 16'd1023);
        cfg_write(CFG_SLICE1, 16'd1023);
        cfg_write(CFG_SLICE2, 16'd1023);
        cfg_write(CFG_THRESHOLD, 16'hFFFF);
        random_phase(250);
        drain();

        // zero slices make no progress; low threshold exercises saturation loops
        cfg_write(CFG_SLICE0, 16'd0);
        cfg_write(CFG_SLICE1, 16'd0);
        cfg_write(CFG_SLICE2, 16'd0);
        cfg_write(CFG_THRESHOLD, 16'd1);
        random_phase(100);
        drain();

        // random mid settings, long hold-off while the sender keeps offering
        cfg_write(CFG_SLICE0, 16'($urandom_range(1, 1023)));
        cfg_write(CFG_SLICE1, 16'($urandom_range(1, 1023)));
        cfg_write(CFG_SLICE2, 16'($urandom_range(1, 1023)));
        cfg_write(CFG_THRESHOLD, 16'($urandom_range(1, 3000)));
        hold_cycles = 600;
        random_phase(300);
        drain();

        cfg_write(CFG_SLICE0, 16'd10);
        cfg_write(CFG_SLICE1, 16'd20);
        cfg_write(CFG_SLICE2, 16'd40);
        cfg_write(CFG_THRESHOLD, 16'd50);
        random_phase(330);
        drain();

        if (errors == 0) begin
            $display("mlfq_scheduler_with_aging_test passed");
        end else begin
            $display("mlfq_scheduler_with_aging_test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ mlfq_scheduler_with_aging.f @@
rtl/mlfq_pkg.sv
rtl/mlfq_ram.sv
rtl/mlfq_ctrl.sv
rtl/mlfq_dp.sv
rtl/mlfq_scheduler_with_aging.sv
verif/mlfq_scheduler_with_aging_test.sv
